>>> rtl/papc_pkg.sv
// papc_pkg: shared types, codes and constants of the pose approach pulse controller
// no dependencies; imported by every module of the block
`default_nettype none

package papc_pkg;

    // angle units: 1/64 degree coarse, 1/16384 degree inside the cordic
    localparam int FULL_TURN  = 23040;
    localparam int HALF_TURN  = 11520;
    localparam int FINE_FULL  = 5898240;
    localparam int FINE_HALF  = 2949120;
    localparam int CORDIC_STEPS = 16;

    localparam int MIN_PULSE       = 70;
    localparam int MAX_DRIVE_PULSE = 220;
    localparam int MAX_TURN_PULSE  = 180;
    localparam int MAX_POWER       = 100;

    localparam int MAX_REQUESTS_LIMIT_DEF = 15;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HDG    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_TOL       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HDG_TOL       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_POWER   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_POWER    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_REQUESTS  = 3'd7;

    typedef enum logic [1:0] {
        ACT_STOP     = 2'd0,
        ACT_TURN_POS = 2'd1,
        ACT_TURN_NEG = 2'd2,
        ACT_DRIVE    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_T,
        ST_DECIDE,
        ST_RUN,
        ST_AIM,
        ST_FINISH
    } state_t;

    // start and completion of an iterative unit
    typedef struct packed {
        logic start;
    } unit_ctrl_t;

    typedef struct packed {
        logic done;
    } unit_stat_t;

    // arctangent of 2^-i in 1/16384 degree
    function automatic logic [19:0] atan_fine(input logic [3:0] idx);
        logic [19:0] v;
        case (idx)
            4'd0:    v = 20'd737280;
            4'd1:    v = 20'd435242;
            4'd2:    v = 20'd229970;
            4'd3:    v = 20'd116736;
            4'd4:    v = 20'd58595;
            4'd5:    v = 20'd29326;
            4'd6:    v = 20'd14667;
            4'd7:    v = 20'd7334;
            4'd8:    v = 20'd3667;
            4'd9:    v = 20'd1833;
            4'd10:   v = 20'd917;
            4'd11:   v = 20'd458;
            4'd12:   v = 20'd229;
            4'd13:   v = 20'd115;
            4'd14:   v = 20'd57;
            default: v = 20'd29;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/papc_cordic.sv
// papc_cordic: iterative vectoring cordic, one micro-rotation per cycle
// depends on papc_pkg; gives the compass bearing of (dx, dy) in 1/64 degree
`default_nettype none

module papc_cordic
    import papc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire unit_ctrl_t         ctrl,
    input  wire logic signed [14:0] dx,
    input  wire logic signed [14:0] dy,
    output unit_stat_t              stat,
    output logic [14:0]             bearing
);

    logic signed [25:0] a_reg, a_next;
    logic signed [25:0] b_reg, b_next;
    logic signed [24:0] z_reg, z_next;
    logic [3:0]         step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    logic               done_reg, done_next;
    logic [14:0]        bearing_reg, bearing_next;

    logic signed [25:0] a_init, b_init, sa, sb;
    logic signed [24:0] atan_s;
    logic [24:0]        z_pos;
    logic [16:0]        z_round;

    // arithmetic shift that truncates toward zero
    function automatic logic signed [25:0] shr_tz(input logic signed [25:0] v,
                                                  input logic [3:0] s);
        logic [25:0] m;
        logic [25:0] q;
        m = v[25] ? 26'(-v) : 26'(v);
        q = m >> s;
        return v[25] ? -signed'(q) : signed'(q);
    endfunction

    always_comb
    begin
        a_init = signed'({{3{dy[14]}}, dy, 8'd0});
        b_init = signed'({{3{dx[14]}}, dx, 8'd0});
        sa     = shr_tz(a_reg, step_reg);
        sb     = shr_tz(b_reg, step_reg);
        atan_s = signed'({5'd0, atan_fine(step_reg)});
        // fold into one full turn, round to 1/64 degree
        z_pos   = z_reg[24] ? 25'(z_reg + 25'(FINE_FULL)) : 25'(z_reg);
        z_round = 17'((z_pos + 25'd128) >> 8);

        a_next       = a_reg;
        b_next       = b_reg;
        z_next       = z_reg;
        step_next    = step_reg;
        busy_next    = busy_reg;
        fin_next     = 1'b0;
        done_next    = done_reg;
        bearing_next = bearing_reg;

        if (ctrl.start)
        begin
            done_next = 1'b0;
            busy_next = 1'b1;
            step_next = 4'd0;
            if (dy[14])
            begin
                a_next = -a_init;
                b_next = -b_init;
                z_next = 25'(FINE_HALF);
            end
            else
            begin
                a_next = a_init;
                b_next = b_init;
                z_next = 25'd0;
            end
        end
        else if (busy_reg)
        begin
            if (b_reg > 26'sd0)
            begin
                a_next = a_reg + sb;
                b_next = b_reg - sa;
                z_next = z_reg + atan_s;
            end
            else
            begin
                a_next = a_reg - sb;
                b_next = b_reg + sa;
                z_next = z_reg - atan_s;
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
            if (z_round >= 17'(FULL_TURN))
                bearing_next = 15'(z_round - 17'(FULL_TURN));
            else
                bearing_next = z_round[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        z_reg       <= z_next;
        step_reg    <= step_next;
        bearing_reg <= bearing_next;
    end

    assign stat.done = done_reg;
    assign bearing   = bearing_reg;

endmodule

`default_nettype wire

>>> rtl/papc_isqrt.sv
// papc_isqrt: bit-pair integer square root, one result bit per cycle
// depends on papc_pkg; floor square root of a 36 bit value
`default_nettype none

module papc_isqrt
    import papc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire unit_ctrl_t  ctrl,
    input  wire logic [35:0] value,
    output unit_stat_t       stat,
    output logic [16:0]      root
);

    logic [35:0] v_reg, v_next;
    logic [35:0] r_reg, r_next;
    logic [4:0]  k_reg, k_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [35:0] bit_w, rb;

    always_comb
    begin
        bit_w = 36'd1 << {k_reg, 1'b0};
        rb    = r_reg + bit_w;

        v_next    = v_reg;
        r_next    = r_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = done_reg;

        if (ctrl.start)
        begin
            v_next    = value;
            r_next    = 36'd0;
            k_next    = 5'd17;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (v_reg >= rb)
            begin
                v_next = v_reg - rb;
                r_next = (r_reg >> 1) + bit_w;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            k_next = k_reg - 5'd1;
            if (k_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        k_reg <= k_next;
    end

    assign stat.done = done_reg;
    assign root      = r_reg[16:0];

endmodule

`default_nettype wire

>>> rtl/pose_approach_pulse_controller.sv
// pose_approach_pulse_controller: top level, sequencer, shared multiplier and result logic
// depends on papc_pkg, papc_cordic, papc_isqrt
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  in        | in_valid / in_stall   | opcode, pose_present, pos_x, pos_y, heading
//  out       | out_valid / out_stall | action, power, pulse_ms, last, success
//  cfg       | cfg_we                | cfg_index, cfg_data
//
// a start request or a reply while idle goes back to idle after evaluate;
// a bad pose goes on to the final step; a pose reply passes the multiply
// and decide steps, and when aiming, outside the position tolerance, also
// waits in the run step for the 18-step square root unit and the cordic
// rst_n clears the sequencer, the approach state and the registers to their defaults
// one request is in work at a time; a finished result waits in the output
// register while the next request is taken, and work stalls only in the last
// step if that register is still full and out_stall is high
`default_nettype none

module pose_approach_pulse_controller
    import papc_pkg::*;
#(
    parameter int unsigned MAX_REQUESTS_LIMIT = MAX_REQUESTS_LIMIT_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    opcode,
    input  wire logic                    pose_present,
    input  wire logic signed [14:0]      pos_x,
    input  wire logic signed [14:0]      pos_y,
    input  wire logic signed [15:0]      heading,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   action,
    output logic [6:0]                   power,
    output logic [7:0]                   pulse_ms,
    output logic                         last,
    output logic                         success,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam logic [7:0] LIMIT = 8'(MAX_REQUESTS_LIMIT);

    // sequencer
    state_t state_reg, state_next;

    // configuration
    logic [13:0] tgt_x_reg, tgt_y_reg, hdg_tol_reg;
    logic [14:0] tgt_hdg_reg;
    logic [11:0] pos_tol_reg;
    logic [6:0]  drive_pwr_reg, turn_pwr_reg;
    logic [3:0]  max_req_reg;

    // approach state
    logic [3:0]  count_reg, count_next;
    logic        within_reg, within_next;
    logic        active_reg, active_next;

    // captured request
    logic        op_reg, present_reg;
    logic [14:0] px_reg, py_reg;
    logic [15:0] ph_reg;

    // shared multiplier and sums
    logic [29:0] sq_reg;
    logic [23:0] tol_sq_reg;
    logic [13:0] mul_a;
    logic [27:0] prod;

    // pending result
    action_t     res_act_reg, res_act_next;
    logic [6:0]  res_pwr_reg, res_pwr_next;
    logic [7:0]  res_ms_reg, res_ms_next;
    logic        res_bad_reg, res_bad_next;
    logic        res_within_reg, res_within_next;
    logic        res_load;

    // output register
    logic        out_valid_reg, out_valid_next;
    action_t     action_reg;
    logic [6:0]  power_reg;
    logic [7:0]  pulse_ms_reg;
    logic        last_reg, success_reg;

    // control
    logic        accept, bad_pose, far, slot_free, finish_go;
    unit_ctrl_t  unit_ctrl;
    unit_stat_t  cordic_stat, sqrt_stat;

    // datapath wires
    logic [15:0]        dx_full, dy_full;
    logic signed [14:0] dx, dy;
    logic [13:0]        dx_mag, dy_mag;
    logic [35:0]        sq25;
    logic [14:0]        bearing;
    logic [16:0]        root;
    logic [14:0]        hdg_src;
    logic signed [16:0] err_raw, err;
    logic [13:0]        err_mag;
    logic [15:0]        mag3;
    logic [9:0]         turn_raw;
    logic [7:0]         turn_ms, drive_ms;
    logic [14:0]        drive_raw;
    action_t            turn_act;
    logic [6:0]         drive_pwr_sat, turn_pwr_sat;
    logic [7:0]         budget;
    logic [3:0]         count_inc;
    logic               ends;

    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign bad_pose  = !present_reg || px_reg[14] || py_reg[14] || ph_reg[15];
    assign far       = sq_reg > {6'd0, tol_sq_reg};

    // offsets to the goal
    always_comb
    begin
        dx_full = {2'b00, tgt_x_reg} - {2'b00, px_reg[13:0]};
        dy_full = {2'b00, tgt_y_reg} - {2'b00, py_reg[13:0]};
        dx      = signed'(dx_full[14:0]);
        dy      = signed'(dy_full[14:0]);
        dx_mag  = dx[14] ? 14'(-dx) : dx[13:0];
        dy_mag  = dy[14] ? 14'(-dy) : dy[13:0];
        sq25    = ({6'd0, sq_reg} << 4) + ({6'd0, sq_reg} << 3) + {6'd0, sq_reg};
    end

    // one multiplier, shared by the x, y and tolerance multiply steps
    always_comb
    begin
        case (state_reg)
            ST_MUL_X: mul_a = dx_mag;
            ST_MUL_Y: mul_a = dy_mag;
            default:  mul_a = {2'b00, pos_tol_reg};
        endcase
        prod = mul_a * mul_a;
    end

    papc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (unit_ctrl),
        .dx      (dx),
        .dy      (dy),
        .stat    (cordic_stat),
        .bearing (bearing)
    );

    papc_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (unit_ctrl),
        .value (sq25),
        .stat  (sqrt_stat),
        .root  (root)
    );

    // heading error, wrapped to a half turn either way, and pulse lengths
    always_comb
    begin
        hdg_src = (state_reg == ST_AIM) ? bearing : tgt_hdg_reg;
        err_raw = signed'({2'b00, hdg_src}) - signed'({1'b0, ph_reg});
        if (err_raw > 17'sd11520)
            err = err_raw - 17'sd23040;
        else if (err_raw < -17'sd11520)
            err = err_raw + 17'sd23040;
        else
            err = err_raw;
        err_mag  = err[16] ? 14'(-err) : err[13:0];
        turn_act = (err > 17'sd0) ? ACT_TURN_POS : ACT_TURN_NEG;

        mag3     = ({2'b00, err_mag} << 1) + {2'b00, err_mag};
        turn_raw = mag3[15:6];
        if (turn_raw < 10'(MIN_PULSE))
            turn_ms = 8'(MIN_PULSE);
        else if (turn_raw > 10'(MAX_TURN_PULSE))
            turn_ms = 8'(MAX_TURN_PULSE);
        else
            turn_ms = turn_raw[7:0];

        drive_raw = root[16:2];
        if (drive_raw < 15'(MIN_PULSE))
            drive_ms = 8'(MIN_PULSE);
        else if (drive_raw > 15'(MAX_DRIVE_PULSE))
            drive_ms = 8'(MAX_DRIVE_PULSE);
        else
            drive_ms = drive_raw[7:0];

        drive_pwr_sat = (drive_pwr_reg > 7'(MAX_POWER)) ? 7'(MAX_POWER) : drive_pwr_reg;
        turn_pwr_sat  = (turn_pwr_reg > 7'(MAX_POWER)) ? 7'(MAX_POWER) : turn_pwr_reg;
    end

    // pick the command: a failure in the evaluate step, else in the decide or aim step
    always_comb
    begin
        res_act_next    = res_act_reg;
        res_pwr_next    = res_pwr_reg;
        res_ms_next     = res_ms_reg;
        res_bad_next    = res_bad_reg;
        res_within_next = res_within_reg;
        res_load        = 1'b0;
        case (state_reg)
            ST_EVAL:
            begin
                // missing or invalid pose ends the approach with failure
                res_act_next    = ACT_STOP;
                res_pwr_next    = 7'd0;
                res_ms_next     = 8'd0;
                res_bad_next    = 1'b1;
                res_within_next = 1'b0;
                res_load        = bad_pose;
            end
            ST_DECIDE:
            begin
                // inside the position tolerance: trim heading or hold
                res_bad_next = 1'b0;
                res_load     = !far;
                if (err_mag <= hdg_tol_reg)
                begin
                    res_act_next    = ACT_STOP;
                    res_pwr_next    = 7'd0;
                    res_ms_next     = 8'd0;
                    res_within_next = 1'b1;
                end
                else
                begin
                    res_act_next    = turn_act;
                    res_pwr_next    = turn_pwr_sat;
                    res_ms_next     = turn_ms;
                    res_within_next = 1'b0;
                end
            end
            ST_AIM:
            begin
                // outside: turn toward the goal or drive at it
                res_bad_next    = 1'b0;
                res_within_next = 1'b0;
                res_load        = 1'b1;
                if (err_mag > hdg_tol_reg)
                begin
                    res_act_next = turn_act;
                    res_pwr_next = turn_pwr_sat;
                    res_ms_next  = turn_ms;
                end
                else
                begin
                    res_act_next = ACT_DRIVE;
                    res_pwr_next = drive_pwr_sat;
                    res_ms_next  = drive_ms;
                end
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_EVAL;
            ST_EVAL:
                if (!op_reg || !active_reg)
                    state_next = ST_IDLE;
                else if (bad_pose)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL_X;
            ST_MUL_X:
                state_next = ST_MUL_Y;
            ST_MUL_Y:
                state_next = ST_MUL_T;
            ST_MUL_T:
                state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = far ? ST_RUN : ST_FINISH;
            ST_RUN:
                if (cordic_stat.done && sqrt_stat.done)
                    state_next = ST_AIM;
            ST_AIM:
                state_next = ST_FINISH;
            ST_FINISH:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall        = 1'b1;
        unit_ctrl.start = 1'b0;
        finish_go       = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall        = 1'b0;
            ST_DECIDE: unit_ctrl.start = far;
            ST_FINISH: finish_go       = slot_free;
            default:   in_stall        = 1'b1;
        endcase
    end

    // request budget and approach bookkeeping
    always_comb
    begin
        if (max_req_reg == 4'd0)
            budget = 8'd1;
        else
            budget = {4'd0, max_req_reg};
        if (budget > LIMIT)
            budget = LIMIT;
        count_inc = count_reg + 4'd1;
        ends      = res_bad_reg || ({4'd0, count_inc} >= budget);

        count_next     = count_reg;
        within_next    = within_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (state_reg == ST_EVAL && !op_reg)
        begin
            // start request restarts the approach
            count_next  = 4'd0;
            within_next = 1'b0;
            active_next = 1'b1;
        end
        else if (finish_go)
        begin
            out_valid_next = 1'b1;
            if (!res_bad_reg)
            begin
                count_next  = count_inc;
                within_next = res_within_reg;
            end
            if (ends)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 4'd0;
            within_reg    <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            tgt_x_reg     <= 14'd0;
            tgt_y_reg     <= 14'd0;
            tgt_hdg_reg   <= 15'd0;
            pos_tol_reg   <= 12'd32;
            hdg_tol_reg   <= 14'd256;
            drive_pwr_reg <= 7'd18;
            turn_pwr_reg  <= 7'd16;
            max_req_reg   <= 4'd3;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            within_reg    <= within_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_X:     tgt_x_reg     <= cfg_data[13:0];
                    CFG_TARGET_Y:     tgt_y_reg     <= cfg_data[13:0];
                    CFG_TARGET_HDG:   tgt_hdg_reg   <= cfg_data[14:0];
                    CFG_POS_TOL:      pos_tol_reg   <= cfg_data[11:0];
                    CFG_HDG_TOL:      hdg_tol_reg   <= cfg_data[13:0];
                    CFG_DRIVE_POWER:  drive_pwr_reg <= cfg_data[6:0];
                    CFG_TURN_POWER:   turn_pwr_reg  <= cfg_data[6:0];
                    CFG_MAX_REQUESTS: max_req_reg   <= cfg_data[3:0];
                    default:          max_req_reg   <= max_req_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            present_reg <= pose_present;
            px_reg      <= pos_x;
            py_reg      <= pos_y;
            ph_reg      <= heading;
        end
        case (state_reg)
            ST_MUL_X: sq_reg     <= {2'b00, prod};
            ST_MUL_Y: sq_reg     <= sq_reg + {2'b00, prod};
            ST_MUL_T: tol_sq_reg <= prod[23:0];
            default:  sq_reg     <= sq_reg;
        endcase
        if (res_load)
        begin
            res_act_reg    <= res_act_next;
            res_pwr_reg    <= res_pwr_next;
            res_ms_reg     <= res_ms_next;
            res_bad_reg    <= res_bad_next;
            res_within_reg <= res_within_next;
        end
        if (finish_go)
        begin
            action_reg   <= res_act_reg;
            power_reg    <= res_pwr_reg;
            pulse_ms_reg <= res_ms_reg;
            last_reg     <= ends;
            success_reg  <= ends && !res_bad_reg && res_within_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign power     = power_reg;
    assign pulse_ms  = pulse_ms_reg;
    assign last      = last_reg;
    assign success   = success_reg;

    // a new result only ever comes from the final step
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared outside the final step");

    // aiming only starts once both iterative units have finished
    a_aim_after_units: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_AIM |-> cordic_stat.done && sqrt_stat.done)
        else $error("aim step reached with a unit still busy");

    // success is only reported on the request that ends an approach
    a_success_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> last)
        else $error("success without last");

    // the units are only launched from the decide step
    a_start_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        unit_ctrl.start |=> state_reg == ST_RUN)
        else $error("units started outside the decide step");

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench: checks the pose approach pulse controller against a predictor of its pulse commands
// depends on papc_pkg and pose_approach_pulse_controller
// directed and random requests under several idling phases and register settings
`default_nettype none

module testbench;
    import papc_pkg::*;

    // result fields as the block presents them
    typedef struct packed {
        logic [1:0] action;
        logic [6:0] power;
        logic [7:0] pulse_ms;
        logic       last;
        logic       success;
    } pulse_cmd_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic opcode;
    logic pose_present;
    logic signed [14:0] pos_x;
    logic signed [14:0] pos_y;
    logic signed [15:0] heading;
    logic out_valid;
    logic out_stall;
    logic [1:0] action;
    logic [6:0] power;
    logic [7:0] pulse_ms;
    logic last;
    logic success;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pose_approach_pulse_controller uut (.*);

    // predictor copy of the registers and approach state
    logic [13:0] goal_x, goal_y;
    logic [14:0] goal_hdg;
    logic [11:0] pos_tol;
    logic [13:0] hdg_tol;
    logic [6:0]  drv_pwr, trn_pwr;
    logic [3:0]  req_budget;
    logic [3:0]  req_count;
    logic        in_tol;
    logic        approaching;

    pulse_cmd_t pending_cmds[$];
    int  mismatches;
    int  cycle_count;
    int  send_idle_pct;
    int  stall_pct;
    bit  all_sent;

    localparam int CYCLE_LIMIT = 2000000;

    longint atan_tab[16] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                             3667, 1833, 917, 458, 229, 115, 57, 29};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint shift_toward_zero(longint v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // compass bearing of (dx, dy) via vectoring cordic, result in 1/64 degree
    function automatic int compass_bearing(longint dx, longint dy);
        longint a, b, z, sa, sb;
        a = dy * 256;
        b = dx * 256;
        z = 0;
        if (dy < 0)
        begin
            a = -a;
            b = -b;
            z = FINE_HALF;
        end
        for (int i = 0; i < 16; i++)
        begin
            sa = shift_toward_zero(a, i);
            sb = shift_toward_zero(b, i);
            if (b > 0)
            begin
                a = a + sb;
                b = b - sa;
                z = z + atan_tab[i];
            end
            else
            begin
                a = a - sb;
                b = b + sa;
                z = z - atan_tab[i];
            end
        end
        while (z < 0)
            z = z + FINE_FULL;
        while (z >= FINE_FULL)
            z = z - FINE_FULL;
        z = (z + 128) / 256;
        if (z >= FULL_TURN)
            z = z - FULL_TURN;
        return int'(z);
    endfunction

    function automatic int wrap_half_turn(int e);
        while (e > HALF_TURN)
            e = e - FULL_TURN;
        while (e < -HALF_TURN)
            e = e + FULL_TURN;
        return e;
    endfunction

    function automatic logic [6:0] clip_power(logic [6:0] p);
        return (p > MAX_POWER) ? 7'(MAX_POWER) : p;
    endfunction

    function automatic pulse_cmd_t turn_pulse(int e);
        pulse_cmd_t c;
        int mag, ms;
        mag = (e < 0) ? -e : e;
        ms = mag * 3 / 64;
        if (ms < MIN_PULSE)
            ms = MIN_PULSE;
        if (ms > MAX_TURN_PULSE)
            ms = MAX_TURN_PULSE;
        c = '0;
        c.action = (e > 0) ? ACT_TURN_POS : ACT_TURN_NEG;
        c.power = clip_power(trn_pwr);
        c.pulse_ms = 8'(ms);
        return c;
    endfunction

    // works out the pulse command, if any, for one accepted request, updating approach state
    task automatic predict_pulse(logic op, logic pp, logic [14:0] x, logic [14:0] y,
                                 logic [15:0] h);
        pulse_cmd_t c;
        longint dx, dy, sq, ms;
        int e, mag, budget;
        c = '0;
        if (op == 1'b0)
        begin
            req_count = 0;
            in_tol = 1'b0;
            approaching = 1'b1;
            return;
        end
        if (!approaching)
            return;
        if (!pp || x[14] || y[14] || h[15])
        begin
            c.last = 1'b1;
            approaching = 1'b0;
            pending_cmds.push_back(c);
            return;
        end
        dx = longint'(goal_x) - longint'(x);
        dy = longint'(goal_y) - longint'(y);
        sq = dx * dx + dy * dy;
        if (sq > longint'(pos_tol) * longint'(pos_tol))
        begin
            e = wrap_half_turn(compass_bearing(dx, dy) - int'(h));
            mag = (e < 0) ? -e : e;
            in_tol = 1'b0;
            if (mag > hdg_tol)
                c = turn_pulse(e);
            else
            begin
                ms = int_sqrt(sq * 25) >>> 2;
                if (ms < MIN_PULSE)
                    ms = MIN_PULSE;
                if (ms > MAX_DRIVE_PULSE)
                    ms = MAX_DRIVE_PULSE;
                c.action = ACT_DRIVE;
                c.power = clip_power(drv_pwr);
                c.pulse_ms = 8'(ms);
            end
        end
        else
        begin
            e = wrap_half_turn(int'(goal_hdg) - int'(h));
            mag = (e < 0) ? -e : e;
            if (mag <= hdg_tol)
                in_tol = 1'b1;
            else
            begin
                in_tol = 1'b0;
                c = turn_pulse(e);
            end
        end
        budget = (req_budget == 0) ? 1 : req_budget;
        if (budget > MAX_REQUESTS_LIMIT_DEF)
            budget = MAX_REQUESTS_LIMIT_DEF;
        req_count = req_count + 1;
        if (req_count >= budget)
        begin
            c.last = 1'b1;
            c.success = in_tol;
            approaching = 1'b0;
        end
        c.last = c.last;
        pending_cmds.push_back(c);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatches++;
    endtask

    // receiver side: random stall and field-by-field comparison
    always @(posedge clk)
    begin
        pulse_cmd_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_cmds.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    want = pending_cmds.pop_front();
                    if (action !== want.action)
                        report_mismatch("action", action, want.action);
                    if (power !== want.power)
                        report_mismatch("power", power, want.power);
                    if (pulse_ms !== want.pulse_ms)
                        report_mismatch("pulse_ms", pulse_ms, want.pulse_ms);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                    if (success !== want.success)
                        report_mismatch("success", success, want.success);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // sends one request, holding it until accepted; valid drops only when idling
    task automatic send_request(logic op, logic pp, logic [14:0] x, logic [14:0] y,
                                logic [15:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        pose_present <= pp;
        pos_x <= x;
        pos_y <= y;
        heading <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pulse(op, pp, x, y, h);
    endtask

    task automatic send_pose(logic [14:0] x, logic [14:0] y, logic [15:0] h);
        send_request(1'b1, 1'b1, x, y, h);
    endtask

    // waits for every expected result plus the longest work time of the block
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        case (idx)
            CFG_TARGET_X:     goal_x = 14'(value);
            CFG_TARGET_Y:     goal_y = 14'(value);
            CFG_TARGET_HDG:   goal_hdg = 15'(value);
            CFG_POS_TOL:      pos_tol = 12'(value);
            CFG_HDG_TOL:      hdg_tol = 14'(value);
            CFG_DRIVE_POWER:  drv_pwr = 7'(value);
            CFG_TURN_POWER:   trn_pwr = 7'(value);
            default:          req_budget = 4'(value);
        endcase
    endtask

    task automatic set_all(int tx, int ty, int th, int pt, int ht, int dp, int tp, int mr);
        drain();
        write_reg(CFG_TARGET_X, tx);
        write_reg(CFG_TARGET_Y, ty);
        write_reg(CFG_TARGET_HDG, th);
        write_reg(CFG_POS_TOL, pt);
        write_reg(CFG_HDG_TOL, ht);
        write_reg(CFG_DRIVE_POWER, dp);
        write_reg(CFG_TURN_POWER, tp);
        write_reg(CFG_MAX_REQUESTS, mr);
        cfg_we <= 1'b0;
    endtask

    // directed: extremes, bad poses, idle replies, restarts, stop and trims
    task automatic test_directed;
        send_pose(15'd100, 15'd100, 16'd0);              // reply while idle: ignored
        send_request(1'b0, 1'b0, 15'h7fff, 15'h7fff, 16'hffff);
        send_pose(15'd0, 15'd0, 16'd0);                  // at goal, stopped
        send_pose(15'd0, 15'd0, 16'd11520);              // trim half turn
        send_pose(15'd16383, 15'd16383, 16'd23039);      // far, turn or drive
        send_request(1'b0, 1'b1, 15'd0, 15'd0, 16'd0);
        send_request(1'b1, 1'b0, 15'd5, 15'd5, 16'd5);   // pose missing
        send_request(1'b0, 1'b1, 15'd0, 15'd0, 16'd0);
        send_pose(15'h4000, 15'd0, 16'd0);               // negative x
        send_request(1'b0, 1'b1, 15'd0, 15'd0, 16'd0);
        send_pose(15'd0, 15'h4000, 16'd0);               // negative y
        send_request(1'b0, 1'b1, 15'd0, 15'd0, 16'd0);
        send_pose(15'd0, 15'd0, 16'h8000);               // negative heading
        send_request(1'b0, 1'b1, 15'd0, 15'd0, 16'd0);
        send_pose(15'd10, 15'd0, 16'h7fff);              // heading above a full turn
        send_request(1'b0, 1'b1, 15'd0, 15'd0, 16'd0);   // restart while active
        send_pose(15'd0, 15'd100, 16'd11520);
        send_pose(15'd0, 15'd100, 16'd0);
        send_pose(15'd50, 15'd50, 16'd0);
    endtask

    // random content: mostly well-formed approaches, some noise
    task automatic random_approaches(int n);
        int cnt, r;
        cnt = 0;
        while (cnt < n)
        begin
            send_request(1'b0, 1'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
            cnt++;
            repeat ($urandom_range(1, 17))
            begin
                r = $urandom_range(99);
                if (r < 6)
                    send_request(1'($urandom), 1'($urandom), 15'($urandom), 15'($urandom),
                                 16'($urandom));
                else if (r < 40)
                    send_pose(15'($urandom_range(goal_x + 40, goal_x > 40 ? goal_x - 40 : 0)),
                              15'($urandom_range(goal_y + 40, goal_y > 40 ? goal_y - 40 : 0)),
                              16'($urandom_range(23039)));
                else if (r < 46)
                    send_pose(15'($urandom_range(16383)), 15'($urandom_range(16383)),
                              16'($urandom_range(32767)));
                else
                    send_pose(15'($urandom_range(16383)), 15'($urandom_range(16383)),
                              16'($urandom_range(23039)));
                cnt++;
            end
        end
    endtask

    task automatic test_phases;
        int mode;
        for (int p = 0; p < 12; p++)
        begin
            mode = p % 4;
            send_idle_pct = (mode == 1 || mode == 3) ? 67 : 0;
            stall_pct = (mode == 2) ? 67 : (mode == 3) ? 11 : 0;
            if (mode == 3)
                send_idle_pct = 11;
            case (p)
                0: set_all(0, 0, 0, 0, 0, 0, 0, 0);
                1: set_all(16383, 16383, 23039, 4095, 11520, 100, 100, 15);
                2: set_all(8000, 8000, 11520, 64, 256, 127, 127, 0);
                3: set_all(100, 16000, 32767, 32, 16383, 50, 70, 4);
                default: set_all($urandom_range(16383), $urandom_range(16383),
                                 $urandom_range(23039), $urandom_range(200),
                                 $urandom_range(11520), $urandom_range(127),
                                 $urandom_range(127), $urandom_range(15));
            endcase
            random_approaches(40);
            if (p == 5)
                drain();      // sender holds off until all results are in
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = 1'b0;
        pose_present = 1'b0;
        pos_x = '0;
        pos_y = '0;
        heading = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        mismatches = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        goal_x = 0;
        goal_y = 0;
        goal_hdg = 0;
        pos_tol = 32;
        hdg_tol = 256;
        drv_pwr = 18;
        trn_pwr = 16;
        req_budget = 3;
        req_count = 0;
        in_tol = 1'b0;
        approaching = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_phases();
        drain();
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
